### src/pic_pkg.sv
// package for the eight-line interrupt controller
// holds item, result and state types, command codes and the priority functions
// no dependencies
`default_nettype none

package pic_pkg;

  localparam int NUM_LINES = 8;
  localparam int IN_TDATA_W = 16;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_LINE  = 2'd2,
    REQ_ACK   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    INIT_IDLE = 2'd0,
    INIT_ICW2 = 2'd1,
    INIT_ICW3 = 2'd2,
    INIT_ICW4 = 2'd3
  } init_step_t;

  // command byte bit positions
  localparam int ICW1_SEL_BIT   = 4;
  localparam int ICW1_LTIM_BIT  = 3;
  localparam int ICW1_SNGL_BIT  = 1;
  localparam int ICW1_IC4_BIT   = 0;
  localparam int OCW3_SEL_BIT   = 3;
  localparam int OCW3_POLL_BIT  = 2;
  localparam int OCW3_RR_BIT    = 1;
  localparam int OCW3_RIS_BIT   = 0;
  localparam int OCW3_ESMM_BIT  = 6;
  localparam int OCW3_SMM_BIT   = 5;
  localparam int ICW4_SFNM_BIT  = 4;
  localparam int ICW4_AEOI_BIT  = 1;

  localparam logic [2:0] CASCADE_LINE  = 3'd2;
  localparam logic [2:0] SPURIOUS_LINE = 3'd7;
  localparam logic [7:0] POLL_FLAG     = 8'h80;

  // ocw2 commands
  localparam logic [2:0] OCW2_RAEOI_CLR = 3'd0;
  localparam logic [2:0] OCW2_NS_EOI    = 3'd1;
  localparam logic [2:0] OCW2_NOP       = 3'd2;
  localparam logic [2:0] OCW2_SP_EOI    = 3'd3;
  localparam logic [2:0] OCW2_RAEOI_SET = 3'd4;
  localparam logic [2:0] OCW2_ROT_NS    = 3'd5;
  localparam logic [2:0] OCW2_SET_PRIO  = 3'd6;
  localparam logic [2:0] OCW2_ROT_SP    = 3'd7;

  typedef struct packed {
    req_type_t  req_type;
    logic       port;
    logic [7:0] write_data;
    logic [2:0] line_index;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_out;
    logic [2:0] int_line;
    logic [7:0] vector;
    logic       cascade_ack;
    logic       halt_request;
  } res_t;

  typedef struct packed {
    logic [7:0] request_bits;
    logic [7:0] last_levels;
    logic [7:0] mask_bits;
    logic [7:0] in_service_bits;
    logic [2:0] rotate_base;
    logic       read_isr_select;
    logic       poll_pending;
    logic       special_mask_on;
    init_step_t init_step;
    logic       aeoi_on;
    logic       aeoi_rotate_on;
    logic       nested_mode_on;
    logic       expect_icw4;
    logic       single_chip;
    logic [4:0] vector_base;
  } state_t;

  // rotated position of the highest priority set bit, 8 when none
  function automatic logic [3:0] rot_prio(input logic [7:0] bits, input logic [2:0] base);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic [3:0]  p;
    dbl = {bits, bits};
    rot = dbl[base +: 8];
    p = 4'd8;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (rot[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  // line that would fire, 8 when none
  function automatic logic [3:0] win_line(input state_t s, input logic master);
    logic [3:0] p;
    logic [3:0] ps;
    logic [7:0] svc;
    p = rot_prio(s.request_bits & ~s.mask_bits, s.rotate_base);
    svc = s.in_service_bits;
    if (s.special_mask_on) begin
      svc = svc & ~s.mask_bits;
    end
    if (s.nested_mode_on && master) begin
      svc[CASCADE_LINE] = 1'b0;
    end
    ps = rot_prio(svc, s.rotate_base);
    if (!p[3] && (p < ps)) begin
      return {1'b0, p[2:0] + s.rotate_base};
    end
    return 4'd8;
  endfunction

  function automatic state_t take_line(input state_t s, input logic [2:0] line);
    state_t t;
    t = s;
    if (s.aeoi_on) begin
      if (s.aeoi_rotate_on) begin
        t.rotate_base = line + 3'd1;
      end
    end else begin
      t.in_service_bits[line] = 1'b1;
    end
    t.request_bits[line] = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

### src/pic_in_reg.sv
// input register stage: unpacks the stream beat into an item
// depends on pic_pkg
`default_nettype none

module pic_in_reg
  import pic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  advance,
  output logic                       item_valid,
  output item_t                      item
);

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type   <= req_type_t'(in_tuser[1:0]);
      item_r.port       <= in_tdata[0];
      item_r.write_data <= in_tdata[8:1];
      item_r.line_index <= in_tdata[11:9];
      item_r.line_level <= in_tdata[12];
    end
  end

endmodule

`default_nettype wire

### src/pic_core.sv
// controller state and the per-transaction update logic
// depends on pic_pkg
`default_nettype none

module pic_core
  import pic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire logic  is_master,
  output res_t       res
);

  state_t st_r;
  state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    state_t     s;
    logic [7:0] v;
    logic [2:0] cmd;
    logic [2:0] line;
    logic [3:0] w;
    logic [3:0] p;
    logic [3:0] w2;
    logic [7:0] rd;
    logic [7:0] vec;
    logic       casc;
    logic       halt;
    s    = st_r;
    v    = item.write_data;
    cmd  = v[7:5];
    line = v[2:0];
    rd   = '0;
    vec  = '0;
    casc = 1'b0;
    halt = 1'b0;
    w    = win_line(st_r, is_master);
    p    = rot_prio(st_r.in_service_bits, st_r.rotate_base);

    unique case (item.req_type)
      REQ_WRITE: begin
        if (!item.port) begin
          if (v[ICW1_SEL_BIT]) begin
            s = '0;
            s.vector_base = st_r.vector_base;
            s.init_step   = INIT_ICW2;
            s.expect_icw4 = v[ICW1_IC4_BIT];
            s.single_chip = v[ICW1_SNGL_BIT];
            halt          = v[ICW1_LTIM_BIT];
          end else if (v[OCW3_SEL_BIT]) begin
            if (v[OCW3_POLL_BIT]) begin
              s.poll_pending = 1'b1;
            end
            if (v[OCW3_RR_BIT]) begin
              s.read_isr_select = v[OCW3_RIS_BIT];
            end
            if (v[OCW3_ESMM_BIT]) begin
              s.special_mask_on = v[OCW3_SMM_BIT];
            end
          end else begin
            unique case (cmd) inside
              OCW2_RAEOI_CLR, OCW2_RAEOI_SET: begin
                s.aeoi_rotate_on = cmd[2];
              end
              OCW2_NS_EOI, OCW2_ROT_NS: begin
                if (!p[3]) begin
                  s.in_service_bits[p[2:0] + st_r.rotate_base] = 1'b0;
                  if (cmd == OCW2_ROT_NS) begin
                    s.rotate_base = p[2:0] + st_r.rotate_base + 3'd1;
                  end
                end
              end
              OCW2_SP_EOI: begin
                s.in_service_bits[line] = 1'b0;
              end
              OCW2_SET_PRIO: begin
                s.rotate_base = line + 3'd1;
              end
              OCW2_ROT_SP: begin
                s.in_service_bits[line] = 1'b0;
                s.rotate_base = line + 3'd1;
              end
              OCW2_NOP: begin
              end
              default: begin
              end
            endcase
          end
        end else begin
          unique case (st_r.init_step)
            INIT_IDLE: s.mask_bits = v;
            INIT_ICW2: begin
              s.vector_base = v[7:3];
              if (st_r.single_chip) begin
                s.init_step = st_r.expect_icw4 ? INIT_ICW4 : INIT_IDLE;
              end else begin
                s.init_step = INIT_ICW3;
              end
            end
            INIT_ICW3: s.init_step = st_r.expect_icw4 ? INIT_ICW4 : INIT_IDLE;
            INIT_ICW4: begin
              s.nested_mode_on = v[ICW4_SFNM_BIT];
              s.aeoi_on        = v[ICW4_AEOI_BIT];
              s.init_step      = INIT_IDLE;
            end
            default: s.init_step = INIT_IDLE;
          endcase
        end
      end
      REQ_READ: begin
        if (st_r.poll_pending) begin
          if (!w[3]) begin
            s  = take_line(st_r, w[2:0]);
            rd = POLL_FLAG | {5'd0, w[2:0]};
          end
          s.poll_pending = 1'b0;
        end else if (!item.port) begin
          rd = st_r.read_isr_select ? st_r.in_service_bits : st_r.request_bits;
        end else begin
          rd = st_r.mask_bits;
        end
      end
      REQ_LINE: begin
        if (item.line_level) begin
          if (!st_r.last_levels[item.line_index]) begin
            s.request_bits[item.line_index] = 1'b1;
          end
          s.last_levels[item.line_index] = 1'b1;
        end else begin
          s.last_levels[item.line_index] = 1'b0;
        end
      end
      REQ_ACK: begin
        if (!w[3]) begin
          casc = (w[2:0] == CASCADE_LINE) && is_master;
          vec  = {st_r.vector_base, w[2:0]};
          s    = take_line(st_r, w[2:0]);
        end else begin
          vec = {st_r.vector_base, SPURIOUS_LINE};
        end
      end
      default: begin
      end
    endcase

    // interrupt output reflects the state left by this transaction
    w2 = win_line(s, is_master);
    st_nxt           = s;
    res.read_data    = rd;
    res.int_out      = !w2[3];
    res.int_line     = w2[3] ? 3'd0 : w2[2:0];
    res.vector       = vec;
    res.cascade_ack  = casc;
    res.halt_request = halt;
  end

endmodule

`default_nettype wire

### src/priority_interrupt_controller_top.sv
// top level of the eight-line interrupt controller: result register and config
// depends on pic_pkg, pic_in_reg, pic_core
//
// Usage:
//   in_* carries one transaction per item: in_tuser holds the request kind
//   (write, read, line change, acknowledge); in_tdata holds the port bit,
//   write byte, line index and line level. out_* returns exactly one result
//   per item: read byte, interrupt output and winning line, acknowledge
//   vector, cascade flag and the level-mode halt flag.
//   A transaction taken into the input register moves on into the result
//   register, with out_tvalid high, when the result side advances.
//   One item is taken every cycle unless the result stalls, set by the single
//   registered rotated priority encode and state update between the registers.
//   cfg_we/cfg_wdata write is_master; write it only while no item is in flight.
//   Synchronous reset (rst_n low) clears all controller state, sets
//   is_master and empties both register stages.
//   When out_tready is low the result holds and the input register fills,
//   after which in_tready drops; no item is lost or repeated.
`default_nettype none

module priority_interrupt_controller_top
  import pic_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // config
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // port, write_data[8], line_index[3], line_level, pad
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // req_type[2]
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // read_data[8], int_out, int_line[3], vector[8],
                                                  // cascade_ack, halt_request, pad
);

  logic  is_master_r;
  logic  out_valid_r;
  res_t  res_r;
  res_t  res;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  fire;

  assign advance = !out_valid_r || out_tready;
  assign fire    = item_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_master_r <= 1'b1;
    end else if (cfg_we) begin
      is_master_r <= cfg_wdata;
    end
  end

  pic_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pic_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .is_master (is_master_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'd0, res_r.halt_request, res_r.cascade_ack, res_r.vector,
                       res_r.int_line, res_r.int_out, res_r.read_data};

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking bench for priority_interrupt_controller_top
// keeps a transaction-level shadow of the controller state and checks every result transaction
// depends on pic_pkg and the controller rtl
module tb;
  import pic_pkg::*;

  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam logic CMD_PORT = 1'b0;
  localparam logic DATA_PORT = 1'b1;

  // shadow of the controller: predicts one result per accepted request
  class pic_shadow;
    bit         master;
    bit [7:0]   irr, last_lvl, imr, isr;
    bit [2:0]   prio_base;
    bit         read_isr, poll_armed, smm, aeoi, aeoi_rotate, sfnm, want_icw4, single;
    init_step_t step;
    bit [4:0]   vec_base;
    res_t       due[$];
    int         err_count;

    function new();
      master = 1'b1;
      clear_all();
      vec_base = '0;
      err_count = 0;
    endfunction

    function void clear_all();
      irr = '0;
      last_lvl = '0;
      imr = '0;
      isr = '0;
      prio_base = '0;
      read_isr = 1'b0;
      poll_armed = 1'b0;
      smm = 1'b0;
      aeoi = 1'b0;
      aeoi_rotate = 1'b0;
      sfnm = 1'b0;
      want_icw4 = 1'b0;
      single = 1'b0;
      step = INIT_IDLE;
    endfunction

    // rotated position of the highest priority set bit, 8 when empty
    function int rank(bit [7:0] bits);
      for (int p = 0; p < NUM_LINES; p++) begin
        if (bits[3'(p) + prio_base]) return p;
      end
      return 8;
    endfunction

    function int winner();
      int       p;
      bit [7:0] svc;
      bit [2:0] ln;
      p = rank(irr & ~imr);
      if (p == 8) return 8;
      svc = isr;
      if (smm) svc = svc & ~imr;
      if (sfnm && master) svc[CASCADE_LINE] = 1'b0;
      if (p < rank(svc)) begin
        ln = 3'(p) + prio_base;
        return int'(ln);
      end
      return 8;
    endfunction

    function void service(bit [2:0] ln);
      if (aeoi) begin
        if (aeoi_rotate) prio_base = ln + 3'd1;
      end else begin
        isr[ln] = 1'b1;
      end
      irr[ln] = 1'b0;
    endfunction

    function bit bus_write(bit port, bit [7:0] v);
      bit       halt;
      bit [2:0] cmd;
      bit [2:0] ln;
      int       p;
      halt = 1'b0;
      if (port == CMD_PORT) begin
        if (v[ICW1_SEL_BIT]) begin
          clear_all();
          step = INIT_ICW2;
          want_icw4 = v[ICW1_IC4_BIT];
          single = v[ICW1_SNGL_BIT];
          halt = v[ICW1_LTIM_BIT];
        end else if (v[OCW3_SEL_BIT]) begin
          if (v[OCW3_POLL_BIT]) poll_armed = 1'b1;
          if (v[OCW3_RR_BIT]) read_isr = v[OCW3_RIS_BIT];
          if (v[OCW3_ESMM_BIT]) smm = v[OCW3_SMM_BIT];
        end else begin
          cmd = v[7:5];
          ln = v[2:0];
          case (cmd)
            OCW2_RAEOI_CLR, OCW2_RAEOI_SET: begin
              aeoi_rotate = (cmd == OCW2_RAEOI_SET);
            end
            OCW2_NS_EOI, OCW2_ROT_NS: begin
              p = rank(isr);
              if (p != 8) begin
                ln = 3'(p) + prio_base;
                isr[ln] = 1'b0;
                if (cmd == OCW2_ROT_NS) prio_base = ln + 3'd1;
              end
            end
            OCW2_SP_EOI: isr[ln] = 1'b0;
            OCW2_SET_PRIO: prio_base = ln + 3'd1;
            OCW2_ROT_SP: begin
              isr[ln] = 1'b0;
              prio_base = ln + 3'd1;
            end
            default: ;
          endcase
        end
      end else begin
        case (step)
          INIT_IDLE: imr = v;
          INIT_ICW2: begin
            vec_base = v[7:3];
            if (single) step = want_icw4 ? INIT_ICW4 : INIT_IDLE;
            else step = INIT_ICW3;
          end
          INIT_ICW3: step = want_icw4 ? INIT_ICW4 : INIT_IDLE;
          default: begin
            sfnm = v[ICW4_SFNM_BIT];
            aeoi = v[ICW4_AEOI_BIT];
            step = INIT_IDLE;
          end
        endcase
      end
      return halt;
    endfunction

    function bit [7:0] bus_read(bit port);
      int w;
      if (poll_armed) begin
        poll_armed = 1'b0;
        w = winner();
        if (w != 8) begin
          service(3'(w));
          return POLL_FLAG | 8'(w);
        end
        return 8'h00;
      end
      if (port == CMD_PORT) return read_isr ? isr : irr;
      return imr;
    endfunction

    function void take_request(logic [IN_TUSER_W-1:0] tuser, logic [IN_TDATA_W-1:0] tdata);
      req_type_t kind;
      bit        port;
      bit [7:0]  wd;
      bit [2:0]  idx;
      bit        lvl;
      int        w;
      res_t      r;
      kind = req_type_t'(tuser);
      port = tdata[0];
      wd = tdata[8:1];
      idx = tdata[11:9];
      lvl = tdata[12];
      r = '0;
      case (kind)
        REQ_WRITE: r.halt_request = bus_write(port, wd);
        REQ_READ: r.read_data = bus_read(port);
        REQ_LINE: begin
          if (lvl) begin
            if (!last_lvl[idx]) irr[idx] = 1'b1;
            last_lvl[idx] = 1'b1;
          end else begin
            last_lvl[idx] = 1'b0;
          end
        end
        default: begin
          w = winner();
          if (w != 8) begin
            r.cascade_ack = (3'(w) == CASCADE_LINE) && master;
            r.vector = {vec_base, 3'(w)};
            service(3'(w));
          end else begin
            r.vector = {vec_base, SPURIOUS_LINE};
          end
        end
      endcase
      w = winner();
      r.int_out = (w != 8);
      r.int_line = (w != 8) ? 3'(w) : 3'd0;
      due.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      err_count++;
    endtask

    task check_outcome(logic [OUT_TDATA_W-1:0] d);
      res_t want;
      res_t got;
      got.read_data = d[7:0];
      got.int_out = d[8];
      got.int_line = d[11:9];
      got.vector = d[19:12];
      got.cascade_ack = d[20];
      got.halt_request = d[21];
      if (due.size() == 0) begin
        report("unexpected result transaction", d[7:0], 8'h00);
        return;
      end
      want = due.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.int_out !== want.int_out) begin
        report("int_out", 8'(got.int_out), 8'(want.int_out));
      end
      if (got.int_line !== want.int_line) begin
        report("int_line", 8'(got.int_line), 8'(want.int_line));
      end
      if (got.vector !== want.vector) report("vector", got.vector, want.vector);
      if (got.cascade_ack !== want.cascade_ack) begin
        report("cascade_ack", 8'(got.cascade_ack), 8'(want.cascade_ack));
      end
      if (got.halt_request !== want.halt_request) begin
        report("halt_request", 8'(got.halt_request), 8'(want.halt_request));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pic_shadow shadow;
  bit        jitter_on;
  bit        hold_go;
  int        hold_left;
  int        cycle_count;

  priority_interrupt_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request builders: fields that the request kind ignores stay random
  function automatic item_t rand_item();
    return item_t'(15'($urandom));
  endfunction

  function automatic item_t mk_write(logic port, logic [7:0] data);
    item_t it;
    it = rand_item();
    it.req_type = REQ_WRITE;
    it.port = port;
    it.write_data = data;
    return it;
  endfunction

  function automatic item_t mk_read(logic port);
    item_t it;
    it = rand_item();
    it.req_type = REQ_READ;
    it.port = port;
    return it;
  endfunction

  function automatic item_t mk_line(logic [2:0] idx, logic lvl);
    item_t it;
    it = rand_item();
    it.req_type = REQ_LINE;
    it.line_index = idx;
    it.line_level = lvl;
    return it;
  endfunction

  function automatic item_t mk_ack();
    item_t it;
    it = rand_item();
    it.req_type = REQ_ACK;
    return it;
  endfunction

  function automatic logic [7:0] icw1_byte(logic ltim, logic sngl, logic ic4);
    logic [7:0] b;
    b = '0;
    b[ICW1_SEL_BIT] = 1'b1;
    b[ICW1_LTIM_BIT] = ltim;
    b[ICW1_SNGL_BIT] = sngl;
    b[ICW1_IC4_BIT] = ic4;
    return b;
  endfunction

  function automatic logic [7:0] icw4_byte(logic nested, logic aeoi_en);
    logic [7:0] b;
    b = '0;
    b[ICW4_SFNM_BIT] = nested;
    b[ICW4_AEOI_BIT] = aeoi_en;
    return b;
  endfunction

  function automatic logic [7:0] ocw2_byte(logic [2:0] cmd, logic [2:0] ln);
    return {cmd, 2'b00, ln};
  endfunction

  function automatic logic [7:0] ocw3_byte(logic esmm, logic smm, logic poll, logic rr,
                                           logic ris);
    logic [7:0] b;
    b = '0;
    b[OCW3_SEL_BIT] = 1'b1;
    b[OCW3_ESMM_BIT] = esmm;
    b[OCW3_SMM_BIT] = smm;
    b[OCW3_POLL_BIT] = poll;
    b[OCW3_RR_BIT] = rr;
    b[OCW3_RIS_BIT] = ris;
    return b;
  endfunction

  task automatic send_item(input item_t it);
    @(negedge clk);
    while (jitter_on && $urandom_range(0, 99) < 8) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = it.req_type;
    in_tdata = {3'b000, it.line_level, it.line_index, it.write_data, it.port};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // is_master changes only with nothing in flight
  task automatic write_master(input logic v);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (shadow.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    shadow.master = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_directed();
    // level mode asked, single chip with icw4, nested and auto eoi
    send_item(mk_write(CMD_PORT, icw1_byte(1'b1, 1'b1, 1'b1)));
    send_item(mk_write(DATA_PORT, 8'hF8));
    send_item(mk_write(DATA_PORT, icw4_byte(1'b1, 1'b1)));
    send_item(mk_line(3'd7, 1'b1));
    send_item(mk_line(3'd0, 1'b1));
    send_item(mk_ack());
    send_item(mk_ack());
    // nothing pending gives the spurious vector
    send_item(mk_ack());
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_RAEOI_SET, 3'd0)));
    send_item(mk_line(CASCADE_LINE, 1'b1));
    send_item(mk_ack());
    // cascaded chip, no icw4
    send_item(mk_write(CMD_PORT, icw1_byte(1'b0, 1'b0, 1'b0)));
    send_item(mk_write(DATA_PORT, 8'h08));
    send_item(mk_write(DATA_PORT, 8'h04));
    send_item(mk_write(DATA_PORT, 8'hFF));
    send_item(mk_line(3'd3, 1'b1));
    send_item(mk_line(3'd5, 1'b1));
    send_item(mk_read(DATA_PORT));
    send_item(mk_write(DATA_PORT, 8'h00));
    send_item(mk_read(CMD_PORT));
    send_item(mk_ack());
    // poll blocked by the in-service line, then special mask lets line 5 through
    send_item(mk_write(CMD_PORT, ocw3_byte(1'b0, 1'b0, 1'b1, 1'b1, 1'b1)));
    send_item(mk_read(CMD_PORT));
    send_item(mk_write(CMD_PORT, ocw3_byte(1'b1, 1'b1, 1'b1, 1'b0, 1'b0)));
    send_item(mk_write(DATA_PORT, 8'h08));
    send_item(mk_read(DATA_PORT));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_NOP, 3'd0)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_ROT_NS, 3'd0)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_NS_EOI, 3'd0)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_SP_EOI, 3'd3)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_SET_PRIO, 3'd7)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_ROT_SP, 3'd4)));
    send_item(mk_write(CMD_PORT, ocw2_byte(OCW2_RAEOI_CLR, 3'd0)));
  endtask

  task automatic run_random(input int n);
    int         done;
    int         pick;
    logic [7:0] b;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_item(mk_line(3'($urandom), 1'($urandom)));
        done++;
      end else if (pick < 52) begin
        send_item(mk_ack());
        done++;
      end else if (pick < 62) begin
        send_item(mk_write(CMD_PORT, ocw2_byte(3'($urandom), 3'($urandom))));
        done++;
      end else if (pick < 69) begin
        send_item(mk_write(CMD_PORT, ocw3_byte(1'($urandom), 1'($urandom), 1'($urandom),
                                               1'($urandom), 1'($urandom))));
        done++;
      end else if (pick < 79) begin
        send_item(mk_read(1'($urandom)));
        done++;
      end else if (pick < 85) begin
        // sparse masks keep most lines live
        send_item(mk_write(DATA_PORT, 8'($urandom & $urandom & $urandom)));
        done++;
      end else if (pick < 91) begin
        b = 8'($urandom);
        b[ICW1_SEL_BIT] = 1'b1;
        send_item(mk_write(CMD_PORT, b));
        send_item(mk_write(DATA_PORT, 8'($urandom)));
        done += 2;
        if (!b[ICW1_SNGL_BIT]) begin
          send_item(mk_write(DATA_PORT, 8'($urandom)));
          done++;
        end
        if (b[ICW1_IC4_BIT]) begin
          send_item(mk_write(DATA_PORT, 8'($urandom)));
          done++;
        end
      end else begin
        send_item(rand_item());
        done++;
      end
    end
  endtask

  // result side ready, with random stalls and one long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = !(jitter_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) shadow.take_request(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_outcome(out_tdata);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    shadow = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    jitter_on = 1'b1;
    hold_go = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    write_master(1'b1);
    run_directed();
    run_random(300);
    // stretch with no stalls on either side
    jitter_on = 1'b0;
    run_random(150);
    jitter_on = 1'b1;
    write_master(1'b0);
    run_random(200);
    write_master(1'b1);
    hold_go = 1'b1;
    run_random(200);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (shadow.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
